// File: sv/tesa_pkg.sv
// Shared types and constants for the two-ended stack allocator.
package tesa_pkg;

	// Command codes
	localparam logic [2:0] CMD_ALLOC_PERM = 3'd0;
	localparam logic [2:0] CMD_ALLOC_TEMP = 3'd1;
	localparam logic [2:0] CMD_FREE_TEMP  = 3'd2;
	localparam logic [2:0] CMD_CLEAR_TEMP = 3'd3;
	localparam logic [2:0] CMD_SET_MARK   = 3'd4;
	localparam logic [2:0] CMD_CLEAR_MARK = 3'd5;
	localparam logic [2:0] CMD_CLEAR_ALL  = 3'd6;
	localparam logic [2:0] CMD_QUERY      = 3'd7;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_NOT_TOP = 2'd2;

	// Side preference codes for a permanent allocation
	localparam logic [1:0] PREF_LOW  = 2'd0;
	localparam logic [1:0] PREF_HIGH = 2'd1;

	// Alignment and header sizes; alignments are powers of two
	localparam int unsigned PERM_ALIGN  = 32;
	localparam int unsigned TEMP_ALIGN  = 8;
	localparam int unsigned TEMP_HEADER = 8;

	localparam logic [30:0] TOTAL_RESET = 31'd134217728;

	// Controller commands to the datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic exec;
		logic load_out;
	} dp_ctl_t;

	// Datapath status to the controller
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

// File: sv/tesa_ctrl.sv
// Sequencing controller for the two-ended stack allocator.
module tesa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tesa_pkg::dp_sts_t sts,
	output tesa_pkg::dp_ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Decode state into datapath commands
	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				ctl.load_in = in_valid;
				if (in_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				ctl.eval = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load_in, ctl.eval, ctl.exec, ctl.load_out}))
		else $error("more than one datapath command at once");

	a_exec_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.eval |=> ctl.exec)
		else $error("side decision not followed by execution");

endmodule

// File: sv/tesa_datapath.sv
// Allocator state registers, command execution and result register.
module tesa_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  tesa_pkg::dp_ctl_t ctl,
	output tesa_pkg::dp_sts_t sts,
	input  logic              cfg_wr_en,
	input  logic [30:0]       cfg_wr_data,
	input  logic [2:0]        cmd,
	input  logic [30:0]       req_size,
	input  logic [1:0]        preference,
	input  logic [30:0]       free_offset,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [30:0]       offset,
	output logic [30:0]       remaining,
	output logic              has_mark
);

	localparam logic [31:0] PERM_MASK = ~(32'(tesa_pkg::PERM_ALIGN) - 32'd1);
	localparam logic [31:0] TEMP_MASK = ~(32'(tesa_pkg::TEMP_ALIGN) - 32'd1);
	localparam logic [31:0] HDR       = 32'(tesa_pkg::TEMP_HEADER);

	function automatic logic [30:0] hi_off(input logic [30:0] tot, input logic [30:0] top);
		logic [30:0] r;
		r = (tot >= top) ? (tot - top) : '0;
		return r;
	endfunction

	// Configuration and allocator state
	logic [30:0] total_q;
	logic [30:0] low_mark_q, low_perm_q, low_temp_q, low_hw_q;
	logic [30:0] high_mark_q, high_perm_q, high_temp_q, high_hw_q;
	logic        perm_is_high_q;
	logic [30:0] low_mark_d, low_perm_d, low_temp_d, low_hw_d;
	logic [30:0] high_mark_d, high_perm_d, high_temp_d, high_hw_d;
	logic        perm_is_high_d;

	// Latched transaction and intermediate results
	logic [2:0]  cmd_q;
	logic [30:0] req_q;
	logic [1:0]  pref_q;
	logic [30:0] foff_q;
	logic        ph_try_q;
	logic [31:0] size_q;
	logic [1:0]  res_status_q;
	logic [30:0] res_offset_q;
	logic [1:0]  res_status_d;
	logic [30:0] res_offset_d;

	// Output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [30:0] offset_q;
	logic [30:0] remaining_q;
	logic        has_mark_q;

	// Side decision signals
	logic        ph;
	logic [30:0] ts_temp, ts_perm, ts_hw, ps_perm, ps_hw;
	logic        swap_ok, swapped, inuse, ph_new;
	logic [31:0] perm_size, temp_size;

	// Execution signals
	logic        p_hi;
	logic [30:0] ep_perm, et_temp, et_perm, et_hw;
	logic [32:0] perm_need, temp_need;
	logic [31:0] newp_sum, newt_sum, hdr_sum, hoff_sum;
	logic [30:0] newp, newt, t_diff;
	logic        fr_top, top_hi, top_lo;

	// Result summary
	logic [30:0] lo_max, hi_max;
	logic [31:0] used;

	// Decide the permanent side and the padded size
	always_comb begin
		ph      = perm_is_high_q;
		ts_temp = ph ? low_temp_q : high_temp_q;
		ts_perm = ph ? low_perm_q : high_perm_q;
		ts_hw   = ph ? low_hw_q : high_hw_q;
		ps_perm = ph ? high_perm_q : low_perm_q;
		ps_hw   = ph ? high_hw_q : low_hw_q;
		inuse   = (ts_temp != ts_perm);
		swap_ok = !inuse &&
			(({1'b0, ts_hw} + {1'b0, ps_perm}) > ({1'b0, ps_hw} + {1'b0, ts_perm}));
		swapped = ph ^ swap_ok;
		ph_new  = ph;
		if (cmd_q == tesa_pkg::CMD_ALLOC_PERM) begin
			if (pref_q == tesa_pkg::PREF_LOW && !inuse) begin
				ph_new = ph ? swapped : ph;
			end else if (pref_q == tesa_pkg::PREF_HIGH && !inuse) begin
				ph_new = ph ? ph : swapped;
			end else begin
				ph_new = swapped;
			end
		end else if (cmd_q == tesa_pkg::CMD_ALLOC_TEMP) begin
			ph_new = swapped;
		end
		perm_size = ({1'b0, req_q} + (32'(tesa_pkg::PERM_ALIGN) - 32'd1)) & PERM_MASK;
		temp_size = (({1'b0, req_q} + (32'(tesa_pkg::TEMP_ALIGN) - 32'd1)) & TEMP_MASK) + HDR;
	end

	// Execute the command against the chosen sides
	always_comb begin
		p_hi    = ph_try_q;
		ep_perm = p_hi ? high_perm_q : low_perm_q;
		et_temp = p_hi ? low_temp_q : high_temp_q;
		et_perm = p_hi ? low_perm_q : high_perm_q;
		et_hw   = p_hi ? low_hw_q : high_hw_q;

		perm_need = {2'b0, low_temp_q} + {2'b0, high_temp_q} + {1'b0, size_q};
		temp_need = {2'b0, et_temp} + {2'b0, ep_perm} + {1'b0, size_q};
		newp_sum  = {1'b0, ep_perm} + size_q;
		newp      = newp_sum[30:0];
		newt_sum  = {1'b0, et_temp} + size_q;
		newt      = newt_sum[30:0];
		hdr_sum   = {1'b0, et_temp} + HDR;
		hoff_sum  = {1'b0, hi_off(total_q, newt)} + HDR;

		t_diff = et_temp - et_perm;
		top_hi = ({1'b0, foff_q} + {1'b0, req_q}) == ({1'b0, et_temp} + HDR);
		top_lo = ({1'b0, foff_q} + {1'b0, et_temp}) == ({1'b0, total_q} + HDR);
		if (et_temp < et_perm || req_q > t_diff) begin
			fr_top = 1'b0;
		end else begin
			fr_top = p_hi ? top_hi : top_lo;
		end

		low_mark_d     = low_mark_q;
		low_perm_d     = low_perm_q;
		low_temp_d     = low_temp_q;
		low_hw_d       = low_hw_q;
		high_mark_d    = high_mark_q;
		high_perm_d    = high_perm_q;
		high_temp_d    = high_temp_q;
		high_hw_d      = high_hw_q;
		perm_is_high_d = perm_is_high_q;
		res_status_d   = tesa_pkg::ST_OK;
		res_offset_d   = '0;

		unique case (cmd_q)
			tesa_pkg::CMD_ALLOC_PERM: begin
				if (perm_need > {2'b0, total_q}) begin
					res_status_d = tesa_pkg::ST_NOSPACE;
				end else begin
					perm_is_high_d = p_hi;
					if (p_hi) begin
						high_perm_d  = newp;
						high_temp_d  = newp;
						res_offset_d = hi_off(total_q, newp);
					end else begin
						low_perm_d   = newp;
						low_temp_d   = newp;
						res_offset_d = ep_perm;
					end
				end
			end
			tesa_pkg::CMD_ALLOC_TEMP: begin
				if (temp_need > {2'b0, total_q}) begin
					res_status_d = tesa_pkg::ST_NOSPACE;
				end else begin
					perm_is_high_d = p_hi;
					if (p_hi) begin
						low_temp_d   = newt;
						res_offset_d = hdr_sum[30:0];
						if (newt > et_hw) begin
							low_hw_d = newt;
						end
					end else begin
						high_temp_d  = newt;
						res_offset_d = hoff_sum[30:0];
						if (newt > et_hw) begin
							high_hw_d = newt;
						end
					end
				end
			end
			tesa_pkg::CMD_FREE_TEMP: begin
				if (fr_top) begin
					if (p_hi) begin
						low_temp_d = et_temp - req_q;
					end else begin
						high_temp_d = et_temp - req_q;
					end
				end else begin
					res_status_d = tesa_pkg::ST_NOT_TOP;
				end
			end
			tesa_pkg::CMD_CLEAR_TEMP: begin
				if (p_hi) begin
					low_temp_d = low_perm_q;
				end else begin
					high_temp_d = high_perm_q;
				end
			end
			tesa_pkg::CMD_SET_MARK: begin
				low_mark_d  = low_perm_q;
				high_mark_d = high_perm_q;
			end
			tesa_pkg::CMD_CLEAR_MARK: begin
				low_perm_d  = low_mark_q;
				low_temp_d  = low_mark_q;
				high_perm_d = high_mark_q;
				high_temp_d = high_mark_q;
			end
			tesa_pkg::CMD_CLEAR_ALL: begin
				low_mark_d     = '0;
				low_perm_d     = '0;
				low_temp_d     = '0;
				low_hw_d       = '0;
				high_mark_d    = '0;
				high_perm_d    = '0;
				high_temp_d    = '0;
				high_hw_d      = '0;
				perm_is_high_d = 1'b0;
			end
			tesa_pkg::CMD_QUERY: begin
				res_status_d = tesa_pkg::ST_OK;
			end
			default: begin
				res_status_d = tesa_pkg::ST_OK;
			end
		endcase
	end

	// Summarize free space between the stacks
	always_comb begin
		lo_max = (low_perm_q > low_temp_q) ? low_perm_q : low_temp_q;
		hi_max = (high_perm_q > high_temp_q) ? high_perm_q : high_temp_q;
		used   = {1'b0, lo_max} + {1'b0, hi_max};
	end

	// Hold configuration and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q        <= tesa_pkg::TOTAL_RESET;
			low_mark_q     <= '0;
			low_perm_q     <= '0;
			low_temp_q     <= '0;
			low_hw_q       <= '0;
			high_mark_q    <= '0;
			high_perm_q    <= '0;
			high_temp_q    <= '0;
			high_hw_q      <= '0;
			perm_is_high_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (ctl.exec) begin
				low_mark_q     <= low_mark_d;
				low_perm_q     <= low_perm_d;
				low_temp_q     <= low_temp_d;
				low_hw_q       <= low_hw_d;
				high_mark_q    <= high_mark_d;
				high_perm_q    <= high_perm_d;
				high_temp_q    <= high_temp_d;
				high_hw_q      <= high_hw_d;
				perm_is_high_q <= perm_is_high_d;
			end
		end
	end

	// Capture the transaction and intermediate results
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= cmd;
			req_q  <= req_size;
			pref_q <= preference;
			foff_q <= free_offset;
		end
		if (ctl.eval) begin
			ph_try_q <= ph_new;
			size_q   <= (cmd_q == tesa_pkg::CMD_ALLOC_PERM) ? perm_size : temp_size;
		end
		if (ctl.exec) begin
			res_status_q <= res_status_d;
			res_offset_q <= res_offset_d;
		end
		if (ctl.load_out) begin
			status_q    <= res_status_q;
			offset_q    <= res_offset_q;
			remaining_q <= (used < {1'b0, total_q}) ? (total_q - used[30:0]) : '0;
			has_mark_q  <= (low_mark_q != '0) || (high_mark_q != '0);
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign offset       = offset_q;
	assign remaining    = remaining_q;
	assign has_mark     = has_mark_q;

	a_nospace_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && res_status_d == tesa_pkg::ST_NOSPACE |=>
		$stable(low_perm_q) && $stable(high_perm_q) && $stable(low_temp_q) &&
		$stable(high_temp_q) && $stable(perm_is_high_q))
		else $error("failed allocation changed allocator state");

	a_swap_idle_temp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && ph_try_q != perm_is_high_q |-> ts_temp == ts_perm)
		else $error("sides swapped with temp memory in use");

	a_hw_covers_temp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && cmd_q == tesa_pkg::CMD_ALLOC_TEMP && res_status_d == tesa_pkg::ST_OK
		|=> (perm_is_high_q ? (low_hw_q >= low_temp_q) : (high_hw_q >= high_temp_q)))
		else $error("temp high-water mark below temp top");

endmodule

// File: sv/two_ended_stack_allocator_core.sv
// Two-ended stack allocator: one command per transaction, one result per command.
// The controller takes each transaction through its accept, decide-side, execute and
// result-load steps and accepts no new one until the result is loaded; a stalled
// result holds the result-load step.
// Reset clears all stack tops, marks and high-water marks, puts the permanent stack
// on the low side and loads total_bytes with 134217728.
module two_ended_stack_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [30:0] req_size,
	input  logic [1:0]  preference,
	input  logic [30:0] free_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [30:0] offset,
	output logic [30:0] remaining,
	output logic        has_mark
);

	tesa_pkg::dp_ctl_t ctl;
	tesa_pkg::dp_sts_t sts;

	// Sequence each transaction
	tesa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Hold state and compute results
	tesa_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.req_size    (req_size),
		.preference  (preference),
		.free_offset (free_offset),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.offset      (offset),
		.remaining   (remaining),
		.has_mark    (has_mark)
	);

endmodule

// File: verif/tesa_alloc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the two-ended stack allocator: predicts every result and compares it.
module tesa_alloc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [30:0] req_size,
	input  logic [1:0]  preference,
	input  logic [30:0] free_offset,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [30:0] offset,
	input  logic [30:0] remaining,
	input  logic        has_mark,
	output int          mismatches,
	output int          pending,
	output logic [30:0] temp_top,
	output logic [30:0] temp_base,
	output logic        temp_is_low
);

	typedef struct packed {
		logic [1:0]  status;
		logic [30:0] offset;
		logic [30:0] remaining;
		logic        has_mark;
	} alloc_result_t;

	// Predicted allocator state; index 0 is the low side, 1 the high side
	logic [30:0]   region_bytes;
	logic [30:0]   mark_top [2];
	logic [30:0]   perm_top [2];
	logic [30:0]   tmp_top [2];
	logic [30:0]   tmp_peak [2];
	logic          perm_high;
	alloc_result_t result_q [$];

	// Expose the temp stack so the stimulus can build frees of the top block
	assign temp_top    = tmp_top[!perm_high];
	assign temp_base   = perm_top[!perm_high];
	assign temp_is_low = perm_high;

	// Return the permanent side after a possible role swap
	function automatic logic pick_perm_side(input logic ph);
		logic ts;
		ts = !ph;
		if (tmp_top[ts] != perm_top[ts])
			return ph;
		if (longint'(tmp_peak[ts]) - longint'(perm_top[ts]) >
				longint'(tmp_peak[ph]) - longint'(perm_top[ph]))
			return ts;
		return ph;
	endfunction

	// Payload offset of a high side block whose stack top is top
	function automatic logic [30:0] high_offset(input logic [30:0] top);
		return (region_bytes >= top) ? region_bytes - top : '0;
	endfunction

	// Drop every stack top, mark and high-water mark
	task automatic clear_stacks;
		for (int s = 0; s < 2; s++) begin
			mark_top[s] = '0;
			perm_top[s] = '0;
			tmp_top[s]  = '0;
			tmp_peak[s] = '0;
		end
		perm_high = 1'b0;
	endtask

	// Apply one command to the predicted state and build its result
	task automatic run_allocator_cmd(input logic [2:0] c, input logic [30:0] req,
			input logic [1:0] pref, input logic [30:0] foff, output alloc_result_t res);
		logic   ph;
		logic   ts;
		logic   busy;
		logic   hit;
		longint size;
		longint lo;
		longint hi;
		longint used;
		res = '0;
		ph = perm_high;
		ts = !perm_high;
		case (c)
		tesa_pkg::CMD_ALLOC_PERM: begin
			busy = tmp_top[ts] != perm_top[ts];
			size = ((longint'(req) + tesa_pkg::PERM_ALIGN - 1) / tesa_pkg::PERM_ALIGN) *
				tesa_pkg::PERM_ALIGN;
			if (pref == tesa_pkg::PREF_LOW && !busy) begin
				if (ph)
					ph = pick_perm_side(ph);
			end else if (pref == tesa_pkg::PREF_HIGH && !busy) begin
				if (!ph)
					ph = pick_perm_side(ph);
			end else begin
				ph = pick_perm_side(ph);
			end
			if (longint'(tmp_top[0]) + longint'(tmp_top[1]) + size >
					longint'(region_bytes)) begin
				res.status = tesa_pkg::ST_NOSPACE;
			end else begin
				perm_high = ph;
				if (!ph)
					res.offset = perm_top[0];
				perm_top[ph] = perm_top[ph] + size[30:0];
				if (ph)
					res.offset = high_offset(perm_top[1]);
				tmp_top[ph] = perm_top[ph];
			end
		end
		tesa_pkg::CMD_ALLOC_TEMP: begin
			ph = pick_perm_side(perm_high);
			ts = !ph;
			size = ((longint'(req) + tesa_pkg::TEMP_ALIGN - 1) / tesa_pkg::TEMP_ALIGN) *
				tesa_pkg::TEMP_ALIGN + tesa_pkg::TEMP_HEADER;
			if (longint'(tmp_top[ts]) + longint'(perm_top[ph]) + size >
					longint'(region_bytes)) begin
				res.status = tesa_pkg::ST_NOSPACE;
			end else begin
				perm_high = ph;
				if (ph) begin
					res.offset = tmp_top[ts] + tesa_pkg::TEMP_HEADER;
					tmp_top[ts] = tmp_top[ts] + size[30:0];
				end else begin
					tmp_top[ts] = tmp_top[ts] + size[30:0];
					res.offset = high_offset(tmp_top[ts]) + tesa_pkg::TEMP_HEADER;
				end
				if (tmp_top[ts] > tmp_peak[ts])
					tmp_peak[ts] = tmp_top[ts];
			end
		end
		tesa_pkg::CMD_FREE_TEMP: begin
			// Release only the block on top of the temp stack
			if (tmp_top[ts] < perm_top[ts] || req > tmp_top[ts] - perm_top[ts])
				hit = 1'b0;
			else if (perm_high)
				hit = longint'(foff) + longint'(req) ==
					longint'(tmp_top[ts]) + tesa_pkg::TEMP_HEADER;
			else
				hit = longint'(foff) + longint'(tmp_top[ts]) ==
					longint'(region_bytes) + tesa_pkg::TEMP_HEADER;
			if (hit)
				tmp_top[ts] = tmp_top[ts] - req;
			else
				res.status = tesa_pkg::ST_NOT_TOP;
		end
		tesa_pkg::CMD_CLEAR_TEMP: tmp_top[ts] = perm_top[ts];
		tesa_pkg::CMD_SET_MARK: begin
			mark_top[0] = perm_top[0];
			mark_top[1] = perm_top[1];
		end
		tesa_pkg::CMD_CLEAR_MARK: begin
			for (int s = 0; s < 2; s++) begin
				perm_top[s] = mark_top[s];
				tmp_top[s]  = mark_top[s];
			end
		end
		tesa_pkg::CMD_CLEAR_ALL: clear_stacks();
		default: ;
		endcase

		// Free space between the two stacks, saturated at zero
		lo = (perm_top[0] > tmp_top[0]) ? perm_top[0] : tmp_top[0];
		hi = (perm_top[1] > tmp_top[1]) ? perm_top[1] : tmp_top[1];
		used = lo + hi;
		res.remaining = (used < longint'(region_bytes)) ? longint'(region_bytes) - used : 0;
		res.has_mark = (mark_top[0] != '0) || (mark_top[1] != '0);
	endtask

	// Count a mismatch; report only the first ten
	task automatic report_mismatch(input alloc_result_t want, input alloc_result_t got,
			input bit orphan);
		if (mismatches < 10) begin
			$display("%0t: %s expected status=%0d offset=%0d remaining=%0d has_mark=%0d",
				$time, orphan ? "result with nothing pending," : "result mismatch,",
				want.status, want.offset, want.remaining, want.has_mark);
			$display("    got status=%0d offset=%0d remaining=%0d has_mark=%0d",
				got.status, got.offset, got.remaining, got.has_mark);
		end
		mismatches++;
	endtask

	// Compare results, track config writes, predict accepted transactions
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		alloc_result_t got;
		if (!arst_n) begin
			clear_stacks();
			region_bytes = tesa_pkg::TOTAL_RESET;
			result_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got.status    = status;
				got.offset    = offset;
				got.remaining = remaining;
				got.has_mark  = has_mark;
				if (result_q.size() == 0) begin
					report_mismatch('0, got, 1'b1);
				end else begin
					want = result_q.pop_front();
					if (got !== want)
						report_mismatch(want, got, 1'b0);
				end
			end
			if (cfg_wr_en)
				region_bytes = cfg_wr_data;
			if (in_valid && !in_stall) begin
				run_allocator_cmd(cmd, req_size, preference, free_offset, want);
				result_q.push_back(want);
			end
		end
		pending = result_q.size();
	end

endmodule

// File: verif/two_ended_stack_allocator_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the two-ended stack allocator: clock, reset, stimulus and verdict.
module two_ended_stack_allocator_core_tb;

	// Preference codes beyond the package's low and high
	localparam logic [1:0] PREF_ANY = 2'd2;
	localparam logic [1:0] PREF_ODD = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [30:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = tesa_pkg::CMD_QUERY;
	logic [30:0] req_size = '0;
	logic [1:0]  preference = tesa_pkg::PREF_LOW;
	logic [30:0] free_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [30:0] offset;
	logic [30:0] remaining;
	logic        has_mark;

	int          mismatches;
	int          pending;
	logic [30:0] temp_top;
	logic [30:0] temp_base;
	logic        temp_is_low;
	logic [30:0] region_cfg = tesa_pkg::TOTAL_RESET;
	bit          idle_on = 1'b1;

	two_ended_stack_allocator_core DUT (.*);

	tesa_alloc_checker alloc_check (.*);

	// Clock: 12 ns period
	always #6 clk = ~clk;

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall = idle_on && ($urandom_range(99) < 32);
	end

	// Present one transaction and hold it until accepted
	task automatic send_command(input logic [2:0] c, input logic [30:0] req,
			input logic [1:0] pref, input logic [30:0] foff);
		while (idle_on && $urandom_range(99) < 32) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		cmd         = c;
		req_size    = req;
		preference  = pref;
		free_offset = foff;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop sending and wait for every pending result
	task automatic drain_results;
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Free the top temp block, or a broken free when well_formed is low
	task automatic send_free(input bit well_formed);
		logic [30:0] span;
		logic [30:0] blk;
		logic [30:0] at;
		span = (temp_top >= temp_base) ? temp_top - temp_base : '0;
		if (span < tesa_pkg::TEMP_ALIGN)
			blk = '0;
		else if ($urandom_range(2) == 0)
			blk = span;
		else
			blk = 31'($urandom_range(1, span / tesa_pkg::TEMP_ALIGN)) * tesa_pkg::TEMP_ALIGN;
		at = temp_is_low ? temp_top + tesa_pkg::TEMP_HEADER - blk :
			region_cfg + tesa_pkg::TEMP_HEADER - temp_top;
		if (!well_formed) begin
			case ($urandom_range(2))
			0: at = at + tesa_pkg::TEMP_ALIGN;
			1: blk = span + tesa_pkg::TEMP_ALIGN;
			default: begin
				at  = $urandom;
				blk = $urandom;
			end
			endcase
		end
		send_command(tesa_pkg::CMD_FREE_TEMP, blk, $urandom_range(3), at);
	endtask

	// Resize the region once idle, then run a stretch of random transactions
	task automatic run_phase(input logic [30:0] bytes, input int items);
		int          pick;
		logic [30:0] req;
		drain_results();
		repeat (4) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = bytes;
		@(negedge clk);
		cfg_wr_en  = 1'b0;
		region_cfg = bytes;
		for (int n = 0; n < items; n++) begin
			// Hold off midway until the block has answered everything
			if (n == items / 2)
				drain_results();
			if ($urandom_range(19) == 0)
				req = $urandom;
			else if ($urandom_range(9) == 0)
				req = $urandom_range(0, bytes);
			else
				req = $urandom_range(0, 120);
			pick = $urandom_range(99);
			if (pick < 30)
				send_command(tesa_pkg::CMD_ALLOC_TEMP, req, $urandom_range(3), $urandom);
			else if (pick < 50)
				send_free($urandom_range(3) != 0);
			else if (pick < 68)
				send_command(tesa_pkg::CMD_ALLOC_PERM, req, $urandom_range(3), $urandom);
			else if (pick < 75)
				send_command(tesa_pkg::CMD_CLEAR_TEMP, $urandom, $urandom_range(3), $urandom);
			else if (pick < 81)
				send_command(tesa_pkg::CMD_SET_MARK, $urandom, $urandom_range(3), $urandom);
			else if (pick < 87)
				send_command(tesa_pkg::CMD_CLEAR_MARK, $urandom, $urandom_range(3), $urandom);
			else if (pick < 90)
				send_command(tesa_pkg::CMD_CLEAR_ALL, $urandom, $urandom_range(3), $urandom);
			else
				send_command(tesa_pkg::CMD_QUERY, $urandom, $urandom_range(3), $urandom);
		end
	endtask

	// Reset, directed checks, random phases, verdict
	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every command, field extremes, swaps and error cases
		send_command(tesa_pkg::CMD_QUERY, '0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd1, tesa_pkg::PREF_HIGH, '0);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd33, PREF_ANY, '0);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd40, PREF_ODD, '0);
		send_command(tesa_pkg::CMD_ALLOC_TEMP, 31'd0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_TEMP, 31'd13, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_FREE_TEMP, 31'd16, tesa_pkg::PREF_LOW, 31'd8);
		send_command(tesa_pkg::CMD_FREE_TEMP, 31'h7FFFFFFF, tesa_pkg::PREF_LOW,
			31'h7FFFFFFF);
		send_free(1'b1);
		send_free(1'b1);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'h7FFFFFFF, PREF_ANY, 31'h7FFFFFFF);
		send_command(tesa_pkg::CMD_ALLOC_TEMP, 31'h7FFFFFFF, tesa_pkg::PREF_HIGH, '0);
		send_command(tesa_pkg::CMD_SET_MARK, '0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd64, tesa_pkg::PREF_HIGH, '0);
		send_command(tesa_pkg::CMD_ALLOC_TEMP, 31'd100, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_CLEAR_MARK, '0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_TEMP, 31'd100, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_CLEAR_TEMP, '0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_TEMP, 31'd40, tesa_pkg::PREF_LOW, '0);
		send_free(1'b1);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd32, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_ALLOC_PERM, 31'd32, tesa_pkg::PREF_HIGH, '0);
		send_command(tesa_pkg::CMD_CLEAR_ALL, '0, tesa_pkg::PREF_LOW, '0);
		send_command(tesa_pkg::CMD_QUERY, 31'h7FFFFFFF, PREF_ODD, 31'h7FFFFFFF);

		// Random: small regions, a shrink below use, both extremes
		run_phase(31'd2048, 120);
		run_phase(31'd96, 60);
		run_phase(31'd0, 30);
		run_phase(31'h7FFFFFFF, 100);
		idle_on = 1'b0;
		run_phase(31'd512, 120);
		idle_on = 1'b1;
		run_phase(tesa_pkg::TOTAL_RESET, 100);
		run_phase(31'd4096, 80);

		drain_results();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
